FILE: rtl/core/ctfu_pkg.sv
// Package for the table-dump text field decoder.
// Holds the decode mode, error codes, character constants and the result type.
// No dependencies; every other file of the block uses it.
`default_nettype none

package ctfu_pkg;

    localparam int ByteW = 8;
    localparam int ErrW  = 3;
    localparam int OctW  = 6;

    localparam logic [ByteW-1:0] ChTab       = 8'h09;
    localparam logic [ByteW-1:0] ChLf        = 8'h0A;
    localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
    localparam logic [ByteW-1:0] ChNullMark  = 8'h4E;
    localparam logic [ByteW-1:0] ChB         = 8'h62;
    localparam logic [ByteW-1:0] ChV         = 8'h76;
    localparam logic [ByteW-1:0] ChF         = 8'h66;
    localparam logic [ByteW-1:0] ChN         = 8'h6E;
    localparam logic [ByteW-1:0] ChT         = 8'h74;
    localparam logic [ByteW-1:0] ChR         = 8'h72;
    localparam logic [ByteW-1:0] CtlBs       = 8'd8;
    localparam logic [ByteW-1:0] CtlVt       = 8'd11;
    localparam logic [ByteW-1:0] CtlFf       = 8'd12;
    localparam logic [ByteW-1:0] CtlLf       = 8'd10;
    localparam logic [ByteW-1:0] CtlTab      = 8'd9;
    localparam logic [ByteW-1:0] CtlCr       = 8'd13;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE          = 3'd0,
        ERR_END_BACKSLASH = 3'd1,
        ERR_END_OCTAL     = 3'd2,
        ERR_BAD_OCTAL     = 3'd3,
        ERR_NULL_NONEMPTY = 3'd4,
        ERR_DATA_AFTER    = 3'd5
    } err_code_t;

    typedef enum logic [5:0] {
        MODE_NORMAL     = 6'b000001,
        MODE_ESC        = 6'b000010,
        MODE_OCT_SECOND = 6'b000100,
        MODE_OCT_THIRD  = 6'b001000,
        MODE_OCT_BAD    = 6'b010000,
        MODE_DRAIN      = 6'b100000
    } mode_t;

    typedef struct packed {
        logic             has_byte;
        logic [ByteW-1:0] out_byte;
        logic             field_end;
        logic             row_end;
        logic             field_null;
        err_code_t        error_code;
    } result_t;

    function automatic logic is_octal(input logic [ByteW-1:0] b);
        return (b[7:3] == 5'b00110);
    endfunction

    // Byte that an escaped character stands for.
    function automatic logic [ByteW-1:0] escape_map(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] v;
        case (b)
            ChB:     v = CtlBs;
            ChV:     v = CtlVt;
            ChF:     v = CtlFf;
            ChN:     v = CtlLf;
            ChT:     v = CtlTab;
            ChR:     v = CtlCr;
            default: v = b;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ctfu_if.sv
// Valid/ready channel interfaces for the field decoder: raw row bytes in, results out.
// Depends on ctfu_pkg for the byte width and the error code type.
`default_nettype none

interface ctfu_line_if;
    logic                      valid;
    logic                      ready;
    logic [ctfu_pkg::ByteW-1:0] line_byte;
    logic                      line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface ctfu_result_if;
    logic                       valid;
    logic                       ready;
    logic                       has_byte;
    logic [ctfu_pkg::ByteW-1:0] out_byte;
    logic                       field_end;
    logic                       row_end;
    logic                       field_null;
    logic [ctfu_pkg::ErrW-1:0]  error_code;

    modport source (output valid, output has_byte, output out_byte, output field_end,
                    output row_end, output field_null, output error_code, input ready);
    modport sink   (input valid, input has_byte, input out_byte, input field_end,
                    input row_end, input field_null, input error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/copy_text_field_unescaper.sv
// Top level of the table-dump text field decoder: input register, decoder, result register.
// Depends on ctfu_pkg, the channel interfaces in ctfu_if and ctfu_decode.
//
// Row bytes enter on the line channel one per transaction, the last byte of a row
// flagged by line_end. Each byte yields zero or one result transaction on the result
// channel, with field and row end marks, a null marker flag and an error code. The
// block takes one byte per cycle when not held up; a byte sits in the input register
// while the escape state machine decodes it, and its result then goes through the result
// register to the result channel. Bytes that make no result pass without waiting for the
// result channel; a byte that makes a result waits only while the result register
// still holds an earlier result that has not been taken.
`default_nettype none

module copy_text_field_unescaper (
    input wire logic   clk,
    input wire logic   rst_n,
    ctfu_line_if.sink     line,
    ctfu_result_if.source result
);

    logic                          s1_valid_reg;
    logic [ctfu_pkg::ByteW-1:0]    s1_byte_reg;
    logic                          s1_end_reg;
    logic                          out_valid_reg;
    ctfu_pkg::result_t             out_res_reg;

    logic                          emit;
    ctfu_pkg::result_t             res;
    logic                          out_free;
    logic                          s1_advance;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_advance = s1_valid_reg && (!emit || out_free);
    assign line.ready = !s1_valid_reg || s1_advance;

    ctfu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .in_byte (s1_byte_reg),
        .in_end  (s1_end_reg),
        .emit    (emit),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (line.ready)
        begin
            s1_valid_reg <= line.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line.ready && line.valid)
        begin
            s1_byte_reg <= line.line_byte;
            s1_end_reg  <= line.line_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_advance && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.has_byte   = out_res_reg.has_byte;
    assign result.out_byte   = out_res_reg.out_byte;
    assign result.field_end  = out_res_reg.field_end;
    assign result.row_end    = out_res_reg.row_end;
    assign result.field_null = out_res_reg.field_null;
    assign result.error_code = out_res_reg.error_code;

endmodule

`default_nettype wire

FILE: rtl/core/ctfu_decode.sv
// Escape state machine and field state of the decoder, with its next-result logic.
// Depends on ctfu_pkg; the state advances only when the top level hands it a byte.
`default_nettype none

module ctfu_decode (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [ctfu_pkg::ByteW-1:0] in_byte,
    input  wire logic                       in_end,
    output      logic                       emit,
    output      ctfu_pkg::result_t          res
);

    ctfu_pkg::mode_t               mode_reg, mode_next;
    logic [ctfu_pkg::OctW-1:0]     oct_reg, oct_next;
    logic                          has_data_reg, has_data_next;
    logic                          null_reg, null_next;
    logic                          dan_reg, dan_next;

    logic                          do_data;
    logic                          do_finish;
    logic                          do_fail;
    ctfu_pkg::err_code_t           fail_code;
    logic                          fin_has;
    logic [ctfu_pkg::ByteW-1:0]    fin_byte;
    logic [ctfu_pkg::ByteW-1:0]    data_val;

    always_comb
    begin
        emit          = 1'b0;
        res           = '0;
        mode_next     = mode_reg;
        oct_next      = oct_reg;
        has_data_next = has_data_reg;
        null_next     = null_reg;
        dan_next      = dan_reg;
        do_data       = 1'b0;
        do_finish     = 1'b0;
        do_fail       = 1'b0;
        fail_code     = ctfu_pkg::ERR_NONE;
        fin_has       = 1'b0;
        fin_byte      = '0;
        data_val      = in_byte;

        unique case (mode_reg)
            ctfu_pkg::MODE_DRAIN:
            begin
                if (in_end)
                begin
                    mode_next     = ctfu_pkg::MODE_NORMAL;
                    oct_next      = '0;
                    has_data_next = 1'b0;
                    null_next     = 1'b0;
                    dan_next      = 1'b0;
                end
            end
            ctfu_pkg::MODE_ESC:
            begin
                if (in_byte == ctfu_pkg::ChNullMark)
                begin
                    if (has_data_reg)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ctfu_pkg::ERR_NULL_NONEMPTY;
                    end
                    else
                    begin
                        null_next     = 1'b1;
                        has_data_next = 1'b1;
                        mode_next     = ctfu_pkg::MODE_NORMAL;
                        do_finish     = in_end;
                    end
                end
                else if (ctfu_pkg::is_octal(in_byte))
                begin
                    if (in_end)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ctfu_pkg::ERR_END_OCTAL;
                    end
                    else
                    begin
                        oct_next  = {3'b000, in_byte[2:0]};
                        mode_next = ctfu_pkg::MODE_OCT_SECOND;
                    end
                end
                else
                begin
                    do_data  = 1'b1;
                    data_val = ctfu_pkg::escape_map(in_byte);
                end
            end
            ctfu_pkg::MODE_OCT_SECOND:
            begin
                if (in_end)
                begin
                    do_fail   = 1'b1;
                    fail_code = ctfu_pkg::ERR_END_OCTAL;
                end
                else if (ctfu_pkg::is_octal(in_byte))
                begin
                    oct_next  = {oct_reg[2:0], in_byte[2:0]};
                    mode_next = ctfu_pkg::MODE_OCT_THIRD;
                end
                else
                begin
                    mode_next = ctfu_pkg::MODE_OCT_BAD;
                end
            end
            ctfu_pkg::MODE_OCT_THIRD:
            begin
                if (!ctfu_pkg::is_octal(in_byte))
                begin
                    do_fail   = 1'b1;
                    fail_code = ctfu_pkg::ERR_BAD_OCTAL;
                end
                else
                begin
                    // The top bit of the first digit falls off the 8-bit result.
                    data_val = {oct_reg[4:0], in_byte[2:0]};
                    oct_next = '0;
                    do_data  = 1'b1;
                end
            end
            ctfu_pkg::MODE_OCT_BAD:
            begin
                do_fail   = 1'b1;
                fail_code = ctfu_pkg::ERR_BAD_OCTAL;
            end
            default:
            begin
                mode_next = ctfu_pkg::MODE_NORMAL;
                if (in_byte == ctfu_pkg::ChTab || in_byte == ctfu_pkg::ChLf)
                begin
                    do_finish = 1'b1;
                end
                else if (in_byte == ctfu_pkg::ChBackslash)
                begin
                    if (in_end)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ctfu_pkg::ERR_END_BACKSLASH;
                    end
                    else
                    begin
                        mode_next = ctfu_pkg::MODE_ESC;
                    end
                end
                else
                begin
                    do_data = 1'b1;
                end
            end
        endcase

        if (do_data)
        begin
            dan_next      = dan_reg | null_reg;
            has_data_next = 1'b1;
            mode_next     = ctfu_pkg::MODE_NORMAL;
            if (in_end)
            begin
                do_finish = 1'b1;
                fin_has   = 1'b1;
                fin_byte  = data_val;
            end
            else
            begin
                emit         = 1'b1;
                res.has_byte = 1'b1;
                res.out_byte = data_val;
            end
        end

        if (do_finish)
        begin
            // A byte behind the null marker is reported when the field closes.
            if (dan_next)
            begin
                do_fail   = 1'b1;
                fail_code = ctfu_pkg::ERR_DATA_AFTER;
            end
            else
            begin
                emit           = 1'b1;
                res.has_byte   = fin_has;
                res.out_byte   = fin_byte;
                res.field_end  = 1'b1;
                res.row_end    = in_end;
                res.field_null = null_next;
                mode_next      = ctfu_pkg::MODE_NORMAL;
                oct_next       = '0;
                has_data_next  = 1'b0;
                null_next      = 1'b0;
                dan_next       = 1'b0;
            end
        end

        if (do_fail)
        begin
            emit           = 1'b1;
            res            = '0;
            res.row_end    = in_end;
            res.error_code = fail_code;
            mode_next      = in_end ? ctfu_pkg::MODE_NORMAL : ctfu_pkg::MODE_DRAIN;
            oct_next       = '0;
            has_data_next  = 1'b0;
            null_next      = 1'b0;
            dan_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ctfu_pkg::MODE_NORMAL;
            oct_reg      <= '0;
            has_data_reg <= 1'b0;
            null_reg     <= 1'b0;
            dan_reg      <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            oct_reg      <= oct_next;
            has_data_reg <= has_data_next;
            null_reg     <= null_next;
            dan_reg      <= dan_next;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for copy_text_field_unescaper: directed table of row bytes, then random rows.
// Results are checked against a predictor of the field decoder kept in this file.
// Depends on ctfu_pkg, the channel interfaces in ctfu_if and the block's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctfu_pkg::*;

    localparam logic [ByteW-1:0] Digit0 = 8'h30;
    localparam logic [ByteW-1:0] Digit7 = 8'h37;
    localparam int WatchLimit = 2000;
    localparam int HoldCycles = 300;
    localparam int DrainCycles = 8;
    localparam int MaxReports = 10;
    localparam int NumDirRows = 40;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [ByteW-1:0] b;
        logic             last;
        row_kind_t        kind;
        result_t          want;
    } stim_row_t;

    typedef struct packed {
        row_kind_t kind;
        result_t   want;
        logic      counted;
    } byte_check_t;

    localparam result_t NoRes = '0;
    localparam logic [ByteW-1:0] EscLetters [6] = '{ChB, ChV, ChF, ChN, ChT, ChR};

    localparam stim_row_t DirRows [NumDirRows] = '{
        '{8'h00, 1'b0, ROW_RESULT, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b1, ROW_RESULT, '{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, ERR_NONE}},
        '{ChTab, 1'b0, ROW_RESULT, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, ERR_NONE}},
        '{ChLf, 1'b1, ROW_RESULT, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE}},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChB, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChV, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChF, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChN, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChT, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChR, 1'b1, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b1, ROW_RESULT, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_END_BACKSLASH}},
        // A field that holds only the null marker.
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChNullMark, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChTab, 1'b1, ROW_PREDICT, NoRes},
        // Data after the null marker is only reported when the field closes.
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChNullMark, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h41, 1'b0, ROW_PREDICT, NoRes},
        '{ChLf, 1'b1, ROW_RESULT, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_DATA_AFTER}},
        // Null marker after data, then the rest of the row is dropped.
        '{8'h41, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChNullMark, 1'b0, ROW_RESULT, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NULL_NONEMPTY}},
        '{ChBackslash, 1'b1, ROW_NO_RESULT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h33, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h37, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h37, 1'b0, ROW_PREDICT, NoRes},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h31, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h78, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h30, 1'b1, ROW_RESULT, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_BAD_OCTAL}},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{8'h32, 1'b1, ROW_RESULT, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_END_OCTAL}},
        '{ChBackslash, 1'b0, ROW_NO_RESULT, NoRes},
        '{ChBackslash, 1'b1, ROW_PREDICT, NoRes}
    };

    logic clk;
    logic rst_n;

    ctfu_line_if   line_ch ();
    ctfu_result_if res_ch ();

    copy_text_field_unescaper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_ch),
        .result (res_ch)
    );

    // Predictor state for the field decoder.
    mode_t          dec_mode;
    logic [OctW-1:0] dec_octal;
    logic           dec_has_data;
    logic           dec_null;
    logic           dec_after_null;

    result_t     decoded_q [$];
    byte_check_t byte_check_q [$];
    logic [8:0]  pend_bytes [$];

    int  send_idle;
    int  recv_idle;
    bit  hold_req;
    int  hold_left;
    int  fresh_bytes;
    int  mismatch_cnt;
    int  quiet_cycles;

    byte_check_t mon_chk;
    result_t     mon_pred;
    result_t     mon_got;
    result_t     mon_want;
    bit          mon_hit;
    bit          mon_drop;

    function automatic bit is_oct_digit(input logic [ByteW-1:0] b);
        return b >= Digit0 && b <= Digit7;
    endfunction

    function automatic void clear_field();
        dec_has_data = 1'b0;
        dec_null = 1'b0;
        dec_after_null = 1'b0;
        dec_octal = '0;
    endfunction

    function automatic bit raise_error(input err_code_t e, input logic last,
                                       output result_t r);
        r = '{1'b0, 8'h00, 1'b0, last, 1'b0, e};
        clear_field();
        dec_mode = last ? MODE_NORMAL : MODE_DRAIN;
        return 1'b1;
    endfunction

    function automatic bit close_field(input logic has, input logic [ByteW-1:0] v,
                                       input logic last, output result_t r);
        if (dec_after_null)
            return raise_error(ERR_DATA_AFTER, last, r);
        r = '{has, v, 1'b1, last, dec_null, ERR_NONE};
        clear_field();
        dec_mode = MODE_NORMAL;
        return 1'b1;
    endfunction

    function automatic bit emit_data(input logic [ByteW-1:0] v, input logic last,
                                     output result_t r);
        if (dec_null)
            dec_after_null = 1'b1;
        dec_has_data = 1'b1;
        dec_mode = MODE_NORMAL;
        if (last)
            return close_field(1'b1, v, last, r);
        r = '{1'b1, v, 1'b0, 1'b0, 1'b0, ERR_NONE};
        return 1'b1;
    endfunction

    // Advances the predictor by one row byte; returns 1 when the byte makes a result.
    function automatic bit unescape_step(input logic [ByteW-1:0] b, input logic last,
                                         output result_t r);
        logic [ByteW-1:0] v;
        r = '0;
        case (dec_mode)
            MODE_DRAIN:
            begin
                if (last)
                begin
                    clear_field();
                    dec_mode = MODE_NORMAL;
                end
                return 1'b0;
            end
            MODE_ESC:
            begin
                if (b == ChNullMark)
                begin
                    if (dec_has_data)
                        return raise_error(ERR_NULL_NONEMPTY, last, r);
                    dec_null = 1'b1;
                    dec_has_data = 1'b1;
                    dec_mode = MODE_NORMAL;
                    if (last)
                        return close_field(1'b0, 8'h00, last, r);
                    return 1'b0;
                end
                if (is_oct_digit(b))
                begin
                    if (last)
                        return raise_error(ERR_END_OCTAL, last, r);
                    dec_octal = {3'b000, b[2:0]};
                    dec_mode = MODE_OCT_SECOND;
                    return 1'b0;
                end
                case (b)
                    ChB:     v = CtlBs;
                    ChV:     v = CtlVt;
                    ChF:     v = CtlFf;
                    ChN:     v = CtlLf;
                    ChT:     v = CtlTab;
                    ChR:     v = CtlCr;
                    default: v = b;
                endcase
                return emit_data(v, last, r);
            end
            MODE_OCT_SECOND:
            begin
                if (last)
                    return raise_error(ERR_END_OCTAL, last, r);
                if (is_oct_digit(b))
                begin
                    dec_octal = {dec_octal[2:0], b[2:0]};
                    dec_mode = MODE_OCT_THIRD;
                end
                else
                    dec_mode = MODE_OCT_BAD;
                return 1'b0;
            end
            MODE_OCT_THIRD:
            begin
                if (!is_oct_digit(b))
                    return raise_error(ERR_BAD_OCTAL, last, r);
                // The top bit of the first digit falls outside the byte.
                v = {dec_octal[4:3], dec_octal[2:0], b[2:0]};
                dec_octal = '0;
                return emit_data(v, last, r);
            end
            MODE_OCT_BAD:
                return raise_error(ERR_BAD_OCTAL, last, r);
            default:
                ;
        endcase
        dec_mode = MODE_NORMAL;
        if (b == ChTab || b == ChLf)
            return close_field(1'b0, 8'h00, last, r);
        if (b == ChBackslash)
        begin
            if (last)
                return raise_error(ERR_END_BACKSLASH, last, r);
            dec_mode = MODE_ESC;
            return 1'b0;
        end
        return emit_data(b, last, r);
    endfunction

    function automatic logic [ByteW-1:0] plain_byte();
        logic [ByteW-1:0] b;
        do
            b = ByteW'($urandom_range(255));
        while (b == ChTab || b == ChLf || b == ChBackslash);
        return b;
    endfunction

    function automatic void push_byte(input logic [ByteW-1:0] b);
        pend_bytes.push_back({1'b0, b});
    endfunction

    // Builds one random row into pend_bytes: mostly well-formed fields, some broken ones.
    function automatic void gen_row();
        int nfields;
        int kind;
        int nelem;
        int sel;
        int keep;
        logic [ByteW-1:0] b;
        if ($urandom_range(99) < 8)
        begin
            // Pure noise, with row ends at random places.
            nelem = $urandom_range(1, 8);
            for (int i = 0; i < nelem; i++)
                pend_bytes.push_back({($urandom_range(15) == 0) || (i == nelem - 1),
                                      ByteW'($urandom_range(255))});
            return;
        end
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                push_byte(ChBackslash);
                push_byte(ChNullMark);
            end
            else if (kind < 13)
            begin
                push_byte(ChBackslash);
                push_byte(ChNullMark);
                push_byte(plain_byte());
            end
            else if (kind < 16)
            begin
                push_byte(plain_byte());
                push_byte(ChBackslash);
                push_byte(ChNullMark);
            end
            else if (kind >= 25)
            begin
                nelem = $urandom_range(1, 6);
                for (int e = 0; e < nelem; e++)
                begin
                    sel = $urandom_range(99);
                    if (sel < 50)
                        push_byte(plain_byte());
                    else if (sel < 70)
                    begin
                        push_byte(ChBackslash);
                        push_byte(EscLetters[$urandom_range(5)]);
                    end
                    else if (sel < 80)
                    begin
                        do
                            b = ByteW'($urandom_range(255));
                        while (is_oct_digit(b) || b == ChNullMark);
                        push_byte(ChBackslash);
                        push_byte(b);
                    end
                    else
                    begin
                        push_byte(ChBackslash);
                        for (int d = 0; d < 3; d++)
                            push_byte(Digit0 + ByteW'($urandom_range(7)));
                    end
                end
            end
            if (f < nfields - 1 || $urandom_range(1) == 1)
                push_byte($urandom_range(1) ? ChTab : ChLf);
        end
        if (pend_bytes.size() == 0)
            push_byte(ChLf);
        sel = $urandom_range(99);
        if (sel < 10)
            pend_bytes[$urandom_range(pend_bytes.size() - 1)] = {1'b0, ByteW'($urandom_range(255))};
        else if (sel < 15)
        begin
            keep = $urandom_range(1, pend_bytes.size());
            while (pend_bytes.size() > keep)
                void'(pend_bytes.pop_back());
        end
        pend_bytes[pend_bytes.size() - 1][8] = 1'b1;
    endfunction

    task automatic offer(input logic [ByteW-1:0] b, input logic last,
                         input row_kind_t kind, input result_t want, input logic counted);
        while ($urandom_range(99) < send_idle)
        begin
            line_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_check_q.push_back('{kind, want, counted});
        line_ch.valid <= 1'b1;
        line_ch.line_byte <= b;
        line_ch.line_end <= last;
        @(posedge clk);
        while (!line_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_all_done();
        line_ch.valid <= 1'b0;
        @(posedge clk);
        while (byte_check_q.size() != 0 || decoded_q.size() != 0)
            @(posedge clk);
    endtask

    always #5 clk = ~clk;

    // Result channel ready: random stalls, and one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HoldCycles;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Predicts on each accepted row byte, then checks each accepted result transaction.
    always @(posedge clk)
    begin
        mon_hit = 1'b0;
        if (line_ch.valid && line_ch.ready)
        begin
            mon_hit = 1'b1;
            mon_chk = byte_check_q.pop_front();
            mon_drop = (dec_mode == MODE_DRAIN);
            if (unescape_step(line_ch.line_byte, line_ch.line_end, mon_pred)
                && mon_chk.kind == ROW_PREDICT)
                decoded_q.push_back(mon_pred);
            if (mon_chk.kind == ROW_RESULT)
                decoded_q.push_back(mon_chk.want);
            if (mon_chk.counted && !mon_drop)
                fresh_bytes++;
        end
        if (res_ch.valid && res_ch.ready)
        begin
            mon_hit = 1'b1;
            mon_got = '{res_ch.has_byte, res_ch.out_byte, res_ch.field_end, res_ch.row_end,
                        res_ch.field_null, err_code_t'(res_ch.error_code)};
            if (decoded_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MaxReports)
                    $display("%0t: unexpected result has=%0d byte=%02h fe=%0d re=%0d null=%0d err=%0d",
                             $realtime, mon_got.has_byte, mon_got.out_byte, mon_got.field_end,
                             mon_got.row_end, mon_got.field_null, mon_got.error_code);
            end
            else
            begin
                mon_want = decoded_q.pop_front();
                if (mon_got !== mon_want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MaxReports)
                        $display({"%0t: mismatch expected has=%0d byte=%02h fe=%0d re=%0d null=%0d",
                                  " err=%0d, got has=%0d byte=%02h fe=%0d re=%0d null=%0d err=%0d"},
                                 $realtime, mon_want.has_byte, mon_want.out_byte,
                                 mon_want.field_end, mon_want.row_end, mon_want.field_null,
                                 mon_want.error_code, mon_got.has_byte, mon_got.out_byte,
                                 mon_got.field_end, mon_got.row_end, mon_got.field_null,
                                 mon_got.error_code);
                end
            end
        end
        if (mon_hit || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int goals [3];
        logic [8:0] item;
        goals = '{280, 570, 850};
        clk = 1'b0;
        rst_n = 1'b0;
        line_ch.valid = 1'b0;
        line_ch.line_byte = '0;
        line_ch.line_end = 1'b0;
        res_ch.ready = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        fresh_bytes = 0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        send_idle = 28;
        recv_idle = 85;
        dec_mode = MODE_NORMAL;
        clear_field();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumDirRows; i++)
            offer(DirRows[i].b, DirRows[i].last, DirRows[i].kind, DirRows[i].want, 1'b0);
        wait_all_done();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 28 : (phase == 1) ? 85 : 0;
            recv_idle = (phase == 0) ? 85 : (phase == 1) ? 28 : 0;
            // With no idling the sender keeps offering while the receiver holds off.
            if (phase == 2)
                hold_req = 1'b1;
            while (fresh_bytes < goals[phase])
            begin
                gen_row();
                while (pend_bytes.size() != 0)
                begin
                    item = pend_bytes.pop_front();
                    offer(item[7:0], item[8], ROW_PREDICT, NoRes, 1'b1);
                end
            end
            wait_all_done();
        end

        repeat (DrainCycles) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
